>>> src/ffba_pkg.sv
// Shared constants, codes and types of the first-fit block allocator.
`default_nettype none
package ffba_pkg;

  // Table geometry and block header size
  localparam int unsigned MAX_BLOCKS   = 64;
  localparam int unsigned IDX_W        = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W        = IDX_W + 1;
  localparam logic [31:0] HEADER_BYTES = 32'd24;

  // Reset values of the configuration registers
  localparam logic [31:0] HEAP_START_RST = 32'd4096;
  localparam logic [31:0] HEAP_END_RST   = 32'd1048576;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_END   = 8'd1;

  // Operation codes (the unused code behaves as allocate)
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_RESIZE  = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOSPACE = 3'd1;
  localparam logic [2:0] ST_ZERO    = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_DOUBLE  = 3'd4;

  // One table entry: user address (header address plus header), length, free mark
  typedef struct packed {
    logic [31:0] user;
    logic [31:0] length;
    logic        free;
  } entry_t;

endpackage : ffba_pkg
`default_nettype wire

>>> src/ffba_if.sv
// Request and result channel interfaces of the allocator.
`default_nettype none
interface ffba_in_if
  import ffba_pkg::*;
  ();
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] req_bytes;
  logic [31:0] user_addr;

  modport source (output valid, output op, output req_bytes, output user_addr,
                  input ready);
  modport sink   (input valid, input op, input req_bytes, input user_addr,
                  output ready);
endinterface : ffba_in_if

interface ffba_out_if
  import ffba_pkg::*;
  ();
  logic        valid;
  logic        ready;
  logic [31:0] result_addr;
  logic [2:0]  status;
  logic [31:0] copy_bytes;

  modport source (output valid, output result_addr, output status, output copy_bytes,
                  input ready);
  modport sink   (input valid, input result_addr, input status, input copy_bytes,
                  output ready);
endinterface : ffba_out_if
`default_nettype wire

>>> src/ffba_table.sv
// Block table memory: one write port, one registered read port.
`default_nettype none
module ffba_table
  import ffba_pkg::*;
(
  input  wire              clk,
  input  wire              we,
  input  wire  [IDX_W-1:0] waddr,
  input  wire  entry_t     wdata,
  input  wire  [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [MAX_BLOCKS];
  entry_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule : ffba_table
`default_nettype wire

>>> src/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: sequencer, scan unit and result register.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+--------------------------------------
//  in_if    | in  | valid / ready       | op, req_bytes, user_addr
//  out_if   | out | valid / ready       | result_addr, status, copy_bytes
//  cfg_*    | in  | cfg_we, no wait     | cfg_index, cfg_wdata (heap_start/end)
//
// One word at a time. A scan walks the block table one entry per cycle through the
// single registered read port; a resize that moves scans the table twice, and a
// finished result waits in S_DONE while the output register is stalled by out_if.ready.
// Reset is synchronous; the table holds no valid bits, only the first block_count
// entries are ever used. in_if.ready is high only while the sequencer idles; a stalled
// result sits in the output register and a new word may enter meanwhile.
`default_nettype none
module first_fit_block_allocator
  import ffba_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  ffba_in_if.sink             in_if,
  ffba_out_if.source          out_if,
  input  wire                 cfg_we,
  input  wire [CFG_IDX_W-1:0] cfg_index,
  input  wire [31:0]          cfg_wdata
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_FIND     = 7'b0000010,
    S_CHECK    = 7'b0000100,
    S_ALLOC    = 7'b0001000,
    S_APPEND   = 7'b0010000,
    S_FREE_OLD = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration and heap state
  logic [31:0]      heap_end_r, brk_r, brk_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Latched request
  logic [1:0]  op_r;
  logic [31:0] req_r, addr_r;
  logic        mv_r, mv_nxt;

  // Scan unit
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pidx_r, pidx_nxt;
  entry_t           rdata;
  logic             hit;

  // Found entry of an address match
  logic [IDX_W-1:0] fidx_r, fidx_nxt;
  entry_t           fent_r, fent_nxt;

  // Result held until the output register is free
  logic [31:0] res_r, res_nxt, copy_r, copy_nxt;
  logic [2:0]  st_r, st_nxt;

  // Output register
  logic        out_valid_r;
  logic [31:0] out_addr_r, out_copy_r;
  logic [2:0]  out_st_r;

  // Table write port
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_waddr;
  entry_t           tbl_wdata;

  // Shared compare unit: length against request
  logic [31:0] cmp_len;
  logic        len_ge;
  logic [33:0] new_break;
  logic        in_acc, out_free;

  ffba_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  assign in_acc   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == S_IDLE);

  assign cmp_len = (state_r == S_CHECK) ? fent_r.length : rdata.length;
  assign len_ge  = (cmp_len >= req_r);
  assign hit     = pend_r && ((state_r == S_FIND) ? (rdata.user == addr_r)
                                                  : (rdata.free && len_ge));
  assign new_break = {2'b00, brk_r} + {2'b00, HEADER_BYTES} + {2'b00, req_r};

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    pidx_nxt  = pidx_r;
    fidx_nxt  = fidx_r;
    fent_nxt  = fent_r;
    mv_nxt    = mv_r;
    res_nxt   = res_r;
    st_nxt    = st_r;
    copy_nxt  = copy_r;
    cnt_nxt   = cnt_r;
    brk_nxt   = brk_r;
    tbl_we    = 1'b0;
    tbl_waddr = pidx_r;
    tbl_wdata = rdata;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          mv_nxt   = 1'b0;
          res_nxt  = '0;
          st_nxt   = ST_OK;
          copy_nxt = '0;
          if (in_if.op == OP_RELEASE) begin
            state_nxt = (in_if.user_addr == '0) ? S_DONE : S_FIND;
          end else if (in_if.op == OP_RESIZE && in_if.user_addr != '0) begin
            state_nxt = S_FIND;
          end else if (in_if.req_bytes == '0) begin
            st_nxt    = ST_ZERO;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_ALLOC;
          end
        end
      end

      // Walk the table for a match (address or fit), one entry per cycle
      S_FIND, S_ALLOC: begin
        if (hit) begin
          pend_nxt = 1'b0;
          if (state_r == S_FIND) begin
            fidx_nxt  = pidx_r;
            fent_nxt  = rdata;
            state_nxt = S_CHECK;
          end else begin
            tbl_we         = 1'b1;
            tbl_waddr      = pidx_r;
            tbl_wdata      = rdata;
            tbl_wdata.free = 1'b0;
            res_nxt        = rdata.user;
            state_nxt      = mv_r ? S_FREE_OLD : S_DONE;
          end
        end else if (!pend_r && idx_r >= cnt_r) begin
          if (state_r == S_FIND) begin
            st_nxt    = ST_UNKNOWN;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_APPEND;
          end
        end else begin
          pend_nxt = (idx_r < cnt_r);
          pidx_nxt = idx_r[IDX_W-1:0];
          if (idx_r < cnt_r) begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      // Decide on the matched block
      S_CHECK: begin
        if (fent_r.free) begin
          st_nxt    = ST_DOUBLE;
          state_nxt = S_DONE;
        end else if (op_r == OP_RELEASE) begin
          tbl_we         = 1'b1;
          tbl_waddr      = fidx_r;
          tbl_wdata      = fent_r;
          tbl_wdata.free = 1'b1;
          state_nxt      = S_DONE;
        end else if (len_ge) begin
          res_nxt   = addr_r;
          state_nxt = S_DONE;
        end else begin
          mv_nxt    = 1'b1;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_ALLOC;
        end
      end

      // No fit: grow the heap at the break, or report no space
      S_APPEND: begin
        if (cnt_r >= CNT_W'(MAX_BLOCKS) || new_break > {2'b00, heap_end_r}) begin
          st_nxt    = ST_NOSPACE;
          res_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          tbl_we           = 1'b1;
          tbl_waddr        = cnt_r[IDX_W-1:0];
          tbl_wdata.user   = brk_r + HEADER_BYTES;
          tbl_wdata.length = req_r;
          tbl_wdata.free   = 1'b0;
          res_nxt          = brk_r + HEADER_BYTES;
          cnt_nxt          = cnt_r + 1'b1;
          brk_nxt          = new_break[31:0];
          state_nxt        = mv_r ? S_FREE_OLD : S_DONE;
        end
      end

      // Moved resize: release the old block
      S_FREE_OLD: begin
        tbl_we         = 1'b1;
        tbl_waddr      = fidx_r;
        tbl_wdata      = fent_r;
        tbl_wdata.free = 1'b1;
        copy_nxt       = fent_r.length;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A heap_start write moves the break, only while the table is empty
    if (cfg_we && cfg_index == CFG_HEAP_START && cnt_r == '0) begin
      brk_nxt = cfg_wdata;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      brk_r        <= HEAP_START_RST;
      heap_end_r   <= HEAP_END_RST;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      brk_r   <= brk_nxt;
      pend_r  <= pend_nxt;
      if (cfg_we && cfg_index == CFG_HEAP_END) begin
        heap_end_r <= cfg_wdata;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pidx_r <= pidx_nxt;
    fidx_r <= fidx_nxt;
    fent_r <= fent_nxt;
    mv_r   <= mv_nxt;
    res_r  <= res_nxt;
    st_r   <= st_nxt;
    copy_r <= copy_nxt;
    if (in_acc) begin
      op_r   <= in_if.op;
      req_r  <= in_if.req_bytes;
      addr_r <= in_if.user_addr;
    end
    if (state_r == S_DONE && out_free) begin
      out_addr_r <= res_r;
      out_st_r   <= st_r;
      out_copy_r <= copy_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.result_addr = out_addr_r;
  assign out_if.status      = out_st_r;
  assign out_if.copy_bytes  = out_copy_r;

endmodule : first_fit_block_allocator
`default_nettype wire
